@@ hdl/u8f_pkg.sv @@
package u8f_pkg;

   // Input and result words
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // One accepted character: up to four bytes and the index of its final byte
   localparam int RunBytes = 4;
   localparam int RunIdxW  = $clog2(RunBytes);

   typedef struct packed {
      logic [RunBytes-1:0][7:0] bytes;
      logic [RunIdxW-1:0]       last_idx;
   } run_type;

   // Run queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // Sequence lengths
   localparam logic [2:0] LenIdle  = 3'd0;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   // Code point limits
   localparam logic [20:0] MinTwo       = 21'h00080;
   localparam logic [20:0] MinThree     = 21'h00800;
   localparam logic [20:0] MinFour      = 21'h10000;
   localparam logic [20:0] MaxCode      = 21'h10FFFF;
   localparam logic [20:0] SurrogateLo  = 21'h0D800;
   localparam logic [20:0] SurrogateHi  = 21'h0DFFF;

endpackage

@@ hdl/u8f_front.sv @@
module u8f_front import u8f_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    push,
   output run_type push_run
);

   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  tail_ff [2];
   logic [7:0]  tail_in [2];
   logic [2:0]  exp_ff, exp_in;
   logic [2:0]  held_ff, held_in;
   logic [20:0] code_ff, code_in;

   logic        accept;
   logic [7:0]  b;
   logic        is_cont;
   logic        pend;
   logic [20:0] code_next;
   logic [2:0]  held_next;

   // Reject overlong forms, surrogates and code points past the last plane
   function automatic logic code_ok(input logic [2:0] len, input logic [20:0] code);
      logic ok;
      ok = 1'b1;
      if (len == LenTwo && code < MinTwo) ok = 1'b0;
      if (len == LenThree && code < MinThree) ok = 1'b0;
      if (len == LenFour && (code < MinFour || code > MaxCode)) ok = 1'b0;
      if (code >= SurrogateLo && code <= SurrogateHi) ok = 1'b0;
      return ok;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.in_byte;
   assign is_cont   = (b[7:6] == 2'b10);
   assign pend      = (exp_ff != LenIdle) && (held_ff >= 3'd1) && (held_ff <= 3'd3)
                      && (held_ff < exp_ff);
   assign code_next = {code_ff[14:0], b[5:0]};
   assign held_next = held_ff + 3'd1;

   // Classify the word and advance the pending sequence
   always_comb begin
      lead_in  = lead_ff;
      tail_in  = tail_ff;
      exp_in   = exp_ff;
      held_in  = held_ff;
      code_in  = code_ff;
      push     = 1'b0;
      push_run.bytes[0] = lead_ff;
      push_run.bytes[1] = (held_ff == 3'd1) ? b : tail_ff[0];
      push_run.bytes[2] = (held_ff == 3'd2) ? b : tail_ff[1];
      push_run.bytes[3] = b;
      push_run.last_idx = RunIdxW'(exp_ff - 3'd1);
      if (accept) begin
         if (pend && is_cont) begin
            if (held_ff == 3'd1) tail_in[0] = b;
            if (held_ff == 3'd2) tail_in[1] = b;
            code_in = code_next;
            held_in = held_next;
            if (held_next == exp_ff) begin
               push    = code_ok(exp_ff, code_next);
               exp_in  = LenIdle;
               held_in = 3'd0;
               code_in = '0;
            end
         end else begin
            exp_in  = LenIdle;
            held_in = 3'd0;
            code_in = '0;
            if (!b[7]) begin
               // ASCII passes as a one-byte run
               push              = 1'b1;
               push_run.bytes[0] = b;
               push_run.last_idx = '0;
            end else if (b[7:5] == 3'b110) begin
               lead_in = b;
               exp_in  = LenTwo;
               held_in = 3'd1;
               code_in = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               lead_in = b;
               exp_in  = LenThree;
               held_in = 3'd1;
               code_in = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
               lead_in = b;
               exp_in  = LenFour;
               held_in = 3'd1;
               code_in = {18'd0, b[2:0]};
            end
         end
         // Drop anything unfinished at the end of a block
         if (req_data.is_last) begin
            exp_in  = LenIdle;
            held_in = 3'd0;
            code_in = '0;
         end
      end
   end

   // Hold sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= LenIdle;
         held_ff <= 3'd0;
         code_ff <= '0;
      end else begin
         exp_ff  <= exp_in;
         held_ff <= held_in;
         code_ff <= code_in;
      end
   end

   // Hold buffered bytes
   always_ff @(posedge clock) begin
      lead_ff <= lead_in;
      tail_ff <= tail_in;
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (exp_ff == LenIdle) |-> (held_ff == 3'd0))
      else $error("bytes held while idle");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      (exp_ff != LenIdle) |-> (held_ff >= 3'd1 && held_ff < exp_ff))
      else $error("held count out of range");

endmodule

@@ hdl/u8f_fifo.sv @@
module u8f_fifo import u8f_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   input  logic    pop,
   output logic    q_valid,
   output logic    q_full,
   output run_type head
);

   run_type             run_ff [QDepth];
   logic [QPtrW-1:0]    wr_ff, wr_in;
   logic [QPtrW-1:0]    rd_ff, rd_in;
   logic [QCntW-1:0]    cnt_ff, cnt_in;

   assign q_valid = (cnt_ff != '0);
   assign q_full  = (cnt_ff == QCntW'(QDepth));
   assign head    = run_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store runs
   always_ff @(posedge clock) begin
      if (push) run_ff[wr_ff] <= push_run;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_full || pop))
      else $error("run queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("run queue underflow");

endmodule

@@ hdl/u8f_back.sv @@
module u8f_back import u8f_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  run_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [RunIdxW-1:0] pos_ff, pos_in;
   logic               valid_ff, valid_in;
   rsp_type            data_ff, data_in;
   logic               load;
   logic               at_end;

   assign load      = q_valid && (!valid_ff || rsp_ready);
   assign at_end    = (pos_ff == head.last_idx);
   assign pop       = load && at_end;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Walk the head run one word per cycle into the output register while it is empty or rsp_ready is high
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         data_in.out_byte = head.bytes[pos_ff];
         data_in.run_last = at_end;
         valid_in         = 1'b1;
         pos_in           = at_end ? '0 : pos_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (pos_ff <= head.last_idx))
      else $error("byte position past end of run");

endmodule

@@ hdl/utf8_validating_byte_filter.sv @@
// UTF-8 validating byte filter.
// req channel: one word per accepted handshake, a raw byte and an is_last flag
// marking the final byte of a block. rsp channel: bytes of well-formed
// characters only, in input order, run_last set on the final byte of each
// character. Both channels use valid/ready.
// The front takes one byte every cycle while the queue is not full and tracks
// the open sequence; a complete, valid character is pushed as a run into a
// four-entry queue. The back drains the queue one byte per cycle into a
// registered output while the receiver is ready. A character's first byte
// reaches rsp through the queue entry and then the output register once the
// byte that completes it (or the ASCII byte) is accepted; its remaining
// bytes follow one per cycle while rsp_ready is high.
// When the receiver stalls, the queue fills and req_ready drops once all four
// entries hold runs; nothing is lost.
// Reset (synchronous, active high) empties the queue and the output register
// and closes any open sequence; the block is ready on the next cycle.
module utf8_validating_byte_filter import u8f_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push;
   run_type push_run;
   logic    pop;
   logic    q_valid;
   logic    q_full;
   run_type head;

   u8f_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_run  (push_run)
   );

   u8f_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .head     (head)
   );

   u8f_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_utf8_validating_byte_filter.sv @@
`timescale 1ns / 1ps

module tb_utf8_validating_byte_filter;
   import u8f_pkg::*;

   localparam int RandomWords = 195;
   localparam int DrainCycles = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Words waiting to be driven, bytes the filter should pass on
   req_type pending_words[$];
   rsp_type expected_bytes[$];

   // Shadow of the filter's open sequence
   logic [7:0]  lead_byte;
   logic [7:0]  tail_bytes[0:2];
   logic [2:0]  seq_len = LenIdle;
   logic [2:0]  held = '0;
   logic [20:0] code_bits = '0;

   int mismatches = 0;
   int gap_left = 0;
   int stall_left = 0;
   int phase_left = 0;
   bit calm = 1'b0;

   utf8_validating_byte_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Alternate between stretches with no idling and stretches with gaps
   always @(posedge clock) begin
      if (phase_left == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         phase_left <= $urandom_range(20, 80);
      end else begin
         phase_left <= phase_left - 1;
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bit code_legal(input logic [2:0] len, input logic [20:0] cp);
      if (len == LenTwo && cp < MinTwo) return 1'b0;
      if (len == LenThree && cp < MinThree) return 1'b0;
      if (len == LenFour && (cp < MinFour || cp > MaxCode)) return 1'b0;
      if (cp >= SurrogateLo && cp <= SurrogateHi) return 1'b0;
      return 1'b1;
   endfunction

   task automatic close_seq();
      seq_len = LenIdle;
      held = '0;
      code_bits = '0;
   endtask

   task automatic open_seq(input logic [7:0] b, input logic [2:0] len, input logic [20:0] cp);
      lead_byte = b;
      seq_len = len;
      held = 3'd1;
      code_bits = cp;
   endtask

   // Append one byte to the expected output
   task automatic expect_byte(input logic [7:0] ob, input logic fin);
      expected_bytes.insert(expected_bytes.size(), rsp_type'{out_byte: ob, run_last: fin});
   endtask

   // Advance the shadow sequence by one accepted word and queue what it releases
   task automatic filter_byte(input req_type w);
      logic [7:0] b;
      int k;
      b = w.in_byte;
      if (seq_len != LenIdle && b[7:6] == 2'b10 && held >= 3'd1 && held <= 3'd3
          && held < seq_len) begin
         tail_bytes[held - 3'd1] = b;
         code_bits = {code_bits[14:0], b[5:0]};
         held = held + 3'd1;
         if (held == seq_len) begin
            if (code_legal(seq_len, code_bits)) begin
               expect_byte(lead_byte, 1'b0);
               for (k = 1; k < int'(seq_len); k++)
                  expect_byte(tail_bytes[k - 1], (k == int'(seq_len) - 1));
            end
            close_seq();
         end
      end else begin
         close_seq();
         if (!b[7])
            expect_byte(b, 1'b1);
         else if (b[7:5] == 3'b110)
            open_seq(b, LenTwo, {16'd0, b[4:0]});
         else if (b[7:4] == 4'b1110)
            open_seq(b, LenThree, {17'd0, b[3:0]});
         else if (b[7:3] == 5'b11110)
            open_seq(b, LenFour, {18'd0, b[2:0]});
      end
      if (w.is_last) close_seq();
   endtask

   task automatic push_word(input logic [7:0] b, input logic last);
      pending_words.insert(pending_words.size(), req_type'{in_byte: b, is_last: last});
   endtask

   // Encode cp in len bytes, queue the first keep of them, flag the final one
   task automatic push_seq(input int len, input logic [20:0] cp, input int keep,
                           input logic last);
      logic [7:0] enc[0:3];
      int i;
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: enc[0] = {3'b110, cp[10:6]};
         3: enc[0] = {4'b1110, cp[15:12]};
         default: enc[0] = {5'b11110, cp[20:18]};
      endcase
      for (i = 1; i < len; i++)
         enc[i] = {2'b10, 6'((cp >> (6 * (len - 1 - i))) & 21'h3F)};
      for (i = 0; i < keep; i++)
         push_word(enc[i], (i == keep - 1) ? last : 1'b0);
   endtask

   function automatic logic [20:0] legal_code(input int len);
      logic [20:0] cp;
      case (len)
         1: cp = 21'($urandom_range(0, 'h7F));
         2: cp = 21'($urandom_range('h80, 'h7FF));
         3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= SurrogateLo && cp <= SurrogateHi) cp = cp - 21'h800;
         end
         default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      return cp;
   endfunction

   // Driver: present queued words, idle between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) filter_byte(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data <= pending_words[0];
               pending_words.delete(0);
               req_valid <= 1'b1;
               gap_left <= idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each accepted word against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: out_byte %h run_last %b",
                           rsp_data.out_byte, rsp_data.run_last);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_bytes[0];
               expected_bytes.delete(0);
               if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last)
               begin
                  if (mismatches < 10)
                     $display("mismatch: out_byte exp %h got %h, run_last exp %b got %b",
                              want.out_byte, rsp_data.out_byte, want.run_last,
                              rsp_data.run_last);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= idle_length();
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int directed_n;
      int r;
      int len;
      // ASCII extremes, one on a block end
      push_word(8'h00, 1'b0);
      push_word(8'h7F, 1'b1);
      // Smallest two-byte, largest three-byte, largest four-byte
      push_seq(2, 21'h80, 2, 1'b0);
      push_seq(3, 21'hFFFF, 3, 1'b0);
      push_seq(4, 21'h10FFFF, 4, 1'b0);
      // Overlong via C0, surrogate, lead beyond F4
      push_seq(2, 21'h00, 2, 1'b0);
      push_seq(3, 21'hD800, 3, 1'b0);
      push_seq(4, 21'h140000, 4, 1'b0);
      // Stray continuation and invalid lead
      push_word(8'hBF, 1'b0);
      push_word(8'hFF, 1'b0);
      // Sequence cut short by ASCII
      push_word(8'hE2, 1'b0);
      push_word(8'h41, 1'b0);
      // Lead on a block end, so its continuation is stray
      push_word(8'hC2, 1'b1);
      push_word(8'h80, 1'b0);
      directed_n = pending_words.size();

      while (pending_words.size() < directed_n + RandomWords) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            len = $urandom_range(1, 4);
            push_seq(len, legal_code(len), len, ($urandom_range(0, 9) == 0));
         end else if (r < 75) begin
            case ($urandom_range(0, 2))
               0: begin
                  len = $urandom_range(2, 4);
                  push_seq(len, legal_code(len - 1), len, 1'b0);
               end
               1: push_seq(3, 21'($urandom_range('hD800, 'hDFFF)), 3, 1'b0);
               default: push_seq(4, 21'($urandom_range('h110000, 'h1FFFFF)), 4, 1'b0);
            endcase
         end else if (r < 85) begin
            len = $urandom_range(2, 4);
            push_seq(len, legal_code(len), $urandom_range(1, len - 1),
                     ($urandom_range(0, 2) == 0));
         end else begin
            push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Hold until every word is in and every expected word is out
      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
         #1;
      end
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DrainCycles) @(posedge clock);
      #1;
      if (expected_bytes.size() != 0)
         $display("%0d expected words never arrived", expected_bytes.size());
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("utf8_validating_byte_filter verification clean");
      end else begin
         $display("utf8_validating_byte_filter verification failed");
      end
      $finish;
   end

   // Timeout
   initial begin
      #2_000_000;
      $display("utf8_validating_byte_filter verification failed");
      $finish;
   end

endmodule

@@ utf8_validating_byte_filter.f @@
hdl/u8f_pkg.sv
hdl/u8f_front.sv
hdl/u8f_fifo.sv
hdl/u8f_back.sv
hdl/utf8_validating_byte_filter.sv
tb/tb_utf8_validating_byte_filter.sv
